// ===== rtl/rpcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Rainbow pixel color generator package
// Widths, constants and the request types that move between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcg_pkg;

  localparam int INDEX_BITS     = 12;
  localparam int LEN_BITS       = 12;
  localparam int CMP_BITS       = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
  localparam int HUE_BITS       = 8;
  localparam int LEVEL_BITS     = 8;
  localparam int PRODUCT_BITS   = 2 * LEVEL_BITS;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = HUE_BITS / BITS_PER_STAGE;
  localparam int NUM_STAGES     = DIV_STAGES + 4;

  localparam logic [LEN_BITS-1:0]   LEN_RESET   = LEN_BITS'(30);
  localparam logic [HUE_BITS-1:0]   SEG1_START  = HUE_BITS'(85);
  localparam logic [HUE_BITS-1:0]   SEG2_START  = HUE_BITS'(170);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX   = LEVEL_BITS'(255);
  localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO  = '0;

  typedef struct packed {
    logic                  in_strip;
    logic [LEN_BITS-1:0]   rem;
    logic [HUE_BITS-1:0]   quo;
    logic [HUE_BITS-1:0]   ofs;
    logic [LEVEL_BITS-1:0] bri;
  } div_item_t;

  typedef struct packed {
    logic                  in_strip;
    logic [LEVEL_BITS-1:0] raw_g;
    logic [LEVEL_BITS-1:0] raw_r;
    logic [LEVEL_BITS-1:0] raw_b;
    logic [LEVEL_BITS-1:0] bri;
  } color_item_t;

  typedef struct packed {
    logic                    in_strip;
    logic [PRODUCT_BITS-1:0] prod_g;
    logic [PRODUCT_BITS-1:0] prod_r;
    logic [PRODUCT_BITS-1:0] prod_b;
  } prod_item_t;

  typedef struct packed {
    logic                  in_strip;
    logic [LEVEL_BITS-1:0] green;
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] blue;
  } level_item_t;

endpackage

`default_nettype wire

// ===== rtl/rpcg_div_stage.sv =====
// ----------------------------------------------------------------------------
// Divider stage
// Two restoring steps of the position-over-length division per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcg_div_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [rpcg_pkg::LEN_BITS-1:0] strip_length,
  input  wire logic                          up_valid,
  input  wire rpcg_pkg::div_item_t           up_item,
  output logic                               valid,
  output rpcg_pkg::div_item_t                item
);

  rpcg_pkg::div_item_t           item_next;
  logic [rpcg_pkg::LEN_BITS:0]   trial;

  always_comb begin
    item_next = up_item;
    trial     = '0;
    for (int k = 0; k < rpcg_pkg::BITS_PER_STAGE; k++) begin
      trial = {item_next.rem, 1'b0};
      if (trial >= {1'b0, strip_length}) begin
        item_next.rem = rpcg_pkg::LEN_BITS'(trial - {1'b0, strip_length});
        item_next.quo = {item_next.quo[rpcg_pkg::HUE_BITS-2:0], 1'b1};
      end else begin
        item_next.rem = trial[rpcg_pkg::LEN_BITS-1:0];
        item_next.quo = {item_next.quo[rpcg_pkg::HUE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpcg_color_stage.sv =====
// ----------------------------------------------------------------------------
// Color wheel stage
// Adds the offset to the spread position and maps the hue to raw ramps.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcg_color_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 up_valid,
  input  wire rpcg_pkg::div_item_t  up_item,
  output logic                      valid,
  output rpcg_pkg::color_item_t     item
);

  rpcg_pkg::color_item_t             item_next;
  logic [rpcg_pkg::HUE_BITS-1:0]     hue;
  logic [rpcg_pkg::HUE_BITS-1:0]     pos;
  logic [rpcg_pkg::LEVEL_BITS-1:0]   rise;
  logic [rpcg_pkg::LEVEL_BITS-1:0]   fall;

  always_comb begin
    hue = up_item.ofs + up_item.quo;
    if (hue < rpcg_pkg::SEG1_START) begin
      pos = hue;
    end else if (hue < rpcg_pkg::SEG2_START) begin
      pos = hue - rpcg_pkg::SEG1_START;
    end else begin
      pos = hue - rpcg_pkg::SEG2_START;
    end
    rise = rpcg_pkg::LEVEL_BITS'({1'b0, pos, 1'b0} + {2'b00, pos});
    fall = rpcg_pkg::LEVEL_MAX - rise;

    item_next.in_strip = up_item.in_strip;
    item_next.bri      = up_item.bri;
    if (hue < rpcg_pkg::SEG1_START) begin
      item_next.raw_r = rise;
      item_next.raw_g = fall;
      item_next.raw_b = rpcg_pkg::LEVEL_ZERO;
    end else if (hue < rpcg_pkg::SEG2_START) begin
      item_next.raw_r = fall;
      item_next.raw_g = rpcg_pkg::LEVEL_ZERO;
      item_next.raw_b = rise;
    end else begin
      item_next.raw_r = rpcg_pkg::LEVEL_ZERO;
      item_next.raw_g = rise;
      item_next.raw_b = fall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpcg_mult_stage.sv =====
// ----------------------------------------------------------------------------
// Brightness multiply stage
// Multiplies each raw channel by the brightness.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcg_mult_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic                  up_valid,
  input  wire rpcg_pkg::color_item_t up_item,
  output logic                       valid,
  output rpcg_pkg::prod_item_t       item
);

  rpcg_pkg::prod_item_t item_next;

  always_comb begin
    item_next.in_strip = up_item.in_strip;
    item_next.prod_g   = up_item.raw_g * up_item.bri;
    item_next.prod_r   = up_item.raw_r * up_item.bri;
    item_next.prod_b   = up_item.raw_b * up_item.bri;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpcg_norm_stage.sv =====
// ----------------------------------------------------------------------------
// Normalize stage
// Divides each product by 255 and blanks pixels outside the strip.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcg_norm_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 up_valid,
  input  wire rpcg_pkg::prod_item_t up_item,
  output logic                      valid,
  output rpcg_pkg::level_item_t     item
);

  rpcg_pkg::level_item_t item_next;

  // Exact floor(x / 255) for any product of two bytes.
  function automatic logic [rpcg_pkg::LEVEL_BITS-1:0] div_by_max(
    input logic [rpcg_pkg::PRODUCT_BITS-1:0] x
  );
    logic [rpcg_pkg::PRODUCT_BITS:0] acc;
    acc = {1'b0, x} + {{(rpcg_pkg::LEVEL_BITS + 1){1'b0}},
                       x[rpcg_pkg::PRODUCT_BITS-1:rpcg_pkg::LEVEL_BITS]} + 1'b1;
    return acc[rpcg_pkg::PRODUCT_BITS-1:rpcg_pkg::LEVEL_BITS];
  endfunction

  always_comb begin
    item_next.in_strip = up_item.in_strip;
    if (up_item.in_strip) begin
      item_next.green = div_by_max(up_item.prod_g);
      item_next.red   = div_by_max(up_item.prod_r);
      item_next.blue  = div_by_max(up_item.prod_b);
    end else begin
      item_next.green = rpcg_pkg::LEVEL_ZERO;
      item_next.red   = rpcg_pkg::LEVEL_ZERO;
      item_next.blue  = rpcg_pkg::LEVEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rainbow_pixel_color_generator.sv =====
// ----------------------------------------------------------------------------
// Rainbow pixel color generator
// A pixel request carries an LED index, a hue offset and a brightness. The
// block spreads the color wheel over strip_length LEDs and returns the scaled
// green, red and blue bytes, with index_valid low and black for an index at
// or beyond the strip length.
// The strip length is written through strip_length_we and strip_length_wdata
// while no request is in flight; it resets to 30.
// Both channels use valid and stall. A new request is taken every cycle while
// pixel_stall is low; results leave in request order. Four of the eight
// stages are the divider, which resolves two quotient bits per stage.
// Reset empties the pipeline. When the receiver stalls, the result holds, and
// empty stages still fill; pixel_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rainbow_pixel_color_generator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             strip_length_we,
  input  wire logic [rpcg_pkg::LEN_BITS-1:0]    strip_length_wdata,
  input  wire logic                             pixel_valid,
  output logic                                  pixel_stall,
  input  wire logic [rpcg_pkg::INDEX_BITS-1:0]  pixel_index,
  input  wire logic [rpcg_pkg::HUE_BITS-1:0]    hue_offset,
  input  wire logic [rpcg_pkg::LEVEL_BITS-1:0]  brightness,
  output logic                                  color_valid,
  input  wire logic                             color_stall,
  output logic [rpcg_pkg::LEVEL_BITS-1:0]       green_level,
  output logic [rpcg_pkg::LEVEL_BITS-1:0]       red_level,
  output logic [rpcg_pkg::LEVEL_BITS-1:0]       blue_level,
  output logic                                  index_valid
);

  localparam int LAST = rpcg_pkg::NUM_STAGES - 1;

  logic [rpcg_pkg::LEN_BITS-1:0]   strip_length;
  logic [rpcg_pkg::NUM_STAGES-1:0] stage_valid;
  logic [rpcg_pkg::NUM_STAGES-1:0] stage_load;
  rpcg_pkg::div_item_t             div_item [rpcg_pkg::DIV_STAGES+1];
  rpcg_pkg::div_item_t             entry_next;
  rpcg_pkg::color_item_t           color_item;
  rpcg_pkg::prod_item_t            prod_item;
  rpcg_pkg::level_item_t           level_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= rpcg_pkg::LEN_RESET;
    end else if (strip_length_we) begin
      strip_length <= strip_length_wdata;
    end
  end

  always_comb begin
    stage_load[LAST] = !stage_valid[LAST] || !color_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      stage_load[i] = !stage_valid[i] || stage_load[i+1];
    end
  end

  assign pixel_stall = !stage_load[0];

  always_comb begin
    entry_next.in_strip = rpcg_pkg::CMP_BITS'(pixel_index)
                        < rpcg_pkg::CMP_BITS'(strip_length);
    entry_next.rem      = rpcg_pkg::LEN_BITS'(pixel_index);
    entry_next.quo      = '0;
    entry_next.ofs      = hue_offset;
    entry_next.bri      = brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (stage_load[0]) begin
      stage_valid[0] <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load[0] && pixel_valid) begin
      div_item[0] <= entry_next;
    end
  end

  for (genvar s = 0; s < rpcg_pkg::DIV_STAGES; s++) begin : g_div
    rpcg_div_stage u_div (
      .clk          (clk),
      .rst          (rst),
      .load         (stage_load[s+1]),
      .strip_length (strip_length),
      .up_valid     (stage_valid[s]),
      .up_item      (div_item[s]),
      .valid        (stage_valid[s+1]),
      .item         (div_item[s+1])
    );
  end

  rpcg_color_stage u_color (
    .clk      (clk),
    .rst      (rst),
    .load     (stage_load[rpcg_pkg::DIV_STAGES+1]),
    .up_valid (stage_valid[rpcg_pkg::DIV_STAGES]),
    .up_item  (div_item[rpcg_pkg::DIV_STAGES]),
    .valid    (stage_valid[rpcg_pkg::DIV_STAGES+1]),
    .item     (color_item)
  );

  rpcg_mult_stage u_mult (
    .clk      (clk),
    .rst      (rst),
    .load     (stage_load[rpcg_pkg::DIV_STAGES+2]),
    .up_valid (stage_valid[rpcg_pkg::DIV_STAGES+1]),
    .up_item  (color_item),
    .valid    (stage_valid[rpcg_pkg::DIV_STAGES+2]),
    .item     (prod_item)
  );

  rpcg_norm_stage u_norm (
    .clk      (clk),
    .rst      (rst),
    .load     (stage_load[LAST]),
    .up_valid (stage_valid[rpcg_pkg::DIV_STAGES+2]),
    .up_item  (prod_item),
    .valid    (stage_valid[LAST]),
    .item     (level_item)
  );

  assign color_valid = stage_valid[LAST];
  assign green_level = level_item.green;
  assign red_level   = level_item.red;
  assign blue_level  = level_item.blue;
  assign index_valid = level_item.in_strip;

endmodule

`default_nettype wire

// ===== rtl/rpcg_checker.sv =====
// ----------------------------------------------------------------------------
// Rainbow pixel color generator checker
// Port-level properties of the pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcg_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             pixel_stall,
  input wire logic                             color_valid,
  input wire logic                             color_stall,
  input wire logic [rpcg_pkg::LEVEL_BITS-1:0]  green_level,
  input wire logic [rpcg_pkg::LEVEL_BITS-1:0]  red_level,
  input wire logic [rpcg_pkg::LEVEL_BITS-1:0]  blue_level,
  input wire logic                             index_valid
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> color_valid && $stable(green_level)
      && $stable(red_level) && $stable(blue_level) && $stable(index_valid))
    else $error("stalled result changed");

  a_black_outside: assert property (@(posedge clk) disable iff (rst)
    color_valid && !index_valid |-> green_level == '0 && red_level == '0
      && blue_level == '0)
    else $error("pixel outside the strip is not black");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("result shown right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> color_valid && color_stall)
    else $error("request stalled while the result side moves");

endmodule

bind rainbow_pixel_color_generator rpcg_checker u_rpcg_checker (.*);

`default_nettype wire
